FILE: hdl/dbh_pkg.sv
package dbh_pkg;

    localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV64_MUL   = 64'h00000100000001b3;
    localparam logic [63:0] GOLDEN_SEED = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MULT_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MULT_B  = 64'h94d049bb133111eb;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_OUT
    } state_t;

    // Which 64-bit multiply the sequencer is on.
    typedef enum logic [2:0] {
        OP_FNV,
        OP_SEC,
        OP_FIN_P_A,
        OP_FIN_P_B,
        OP_FIN_S_A,
        OP_FIN_S_B
    } mul_op_t;

    typedef struct packed {
        logic        start;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    function automatic logic [63:0] rotl13(input logic [63:0] v);
        rotl13 = {v[50:0], v[63:51]};
    endfunction

endpackage

FILE: hdl/dbh_mul64.sv
module dbh_mul64
    import dbh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] mul_x;
    logic [31:0] mul_y;

    // Low 64 bits of a*b: lo*lo, plus the low halves of both cross terms shifted up 32.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
        endcase
    end

    always_comb
    begin
        case (step_reg)
            2'd0:    acc_next = acc_reg;
            2'd1:    acc_next = prod_reg;
            default: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.op_a;
            b_reg <= req.op_b;
        end
        if (busy_reg)
        begin
            prod_reg <= 64'(mul_x) * 64'(mul_y);
            acc_reg  <= acc_next;
        end
    end

    assign rsp = '{done: done_reg, product: acc_reg};

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg && !done_reg)
        else $error("multiply started while busy");

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && $past(step_reg) == 2'd3)
        else $error("done without final step");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

endmodule

FILE: hdl/dual_64bit_byte_hash.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_byte[7:0], last
// out       output     out_valid / out_ready  digest_high[63:0], digest_low[63:0]
//
// A byte marked last also runs the finalizer, then may wait for the output.
// Every 64-bit multiply runs on one shared 32x32 multiplier as three partial products;
// a byte needs two, the finalizer four more.
// Reset puts both lanes at their seeds and empties the output register.
// A held digest does not stop new bytes; only the next digest waits for out_ready.
module dual_64bit_byte_hash
    import dbh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_high,
    output logic [63:0] digest_low
);

    state_t      state_reg;
    state_t      state_next;
    mul_op_t     op_reg;
    mul_op_t     op_next;
    logic [63:0] prim_reg;
    logic [63:0] prim_next;
    logic [63:0] sec_reg;
    logic [63:0] sec_next;
    logic [63:0] sum_reg;
    logic [63:0] sum_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] digest_high_reg;
    logic [63:0] digest_low_reg;
    logic        in_accept;
    logic        out_load;
    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    mul_req_t    mreq;
    mul_rsp_t    mrsp;

    dbh_mul64 u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign mreq      = '{start: mul_start, op_a: mul_a, op_b: mul_b};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                    op_next    = OP_FNV;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = S_START;
                    case (op_reg)
                        OP_FNV:     op_next = OP_SEC;
                        OP_SEC:
                        begin
                            if (last_reg)
                                op_next = OP_FIN_P_A;
                            else
                                state_next = S_IDLE;
                        end
                        OP_FIN_P_A: op_next = OP_FIN_P_B;
                        OP_FIN_P_B: op_next = OP_FIN_S_A;
                        OP_FIN_S_A: op_next = OP_FIN_S_B;
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready  = 1'b1;
            S_START: mul_start = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                mul_start = 1'b0;
            end
        endcase
    end

    // Operands of the multiply that the sequencer is about to start.
    always_comb
    begin
        case (op_reg)
            OP_FNV:
            begin
                mul_a = prim_reg ^ {56'd0, byte_reg};
                mul_b = FNV64_MUL;
            end
            OP_SEC:
            begin
                mul_a = rotl13(sec_reg ^ (sum_reg + (sec_reg >> 2)));
                mul_b = MIX_MULT_A;
            end
            OP_FIN_P_A:
            begin
                mul_a = prim_reg ^ (prim_reg >> 30);
                mul_b = MIX_MULT_A;
            end
            OP_FIN_P_B:
            begin
                mul_a = prim_reg ^ (prim_reg >> 27);
                mul_b = MIX_MULT_B;
            end
            OP_FIN_S_A:
            begin
                mul_a = sec_reg ^ (sec_reg >> 30);
                mul_b = MIX_MULT_A;
            end
            default:
            begin
                mul_a = sec_reg ^ (sec_reg >> 27);
                mul_b = MIX_MULT_B;
            end
        endcase
    end

    always_comb
    begin
        prim_next      = prim_reg;
        sec_next       = sec_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_accept)
            sum_next = {56'd0, data_byte} + GOLDEN_SEED + (sec_reg << 6);
        if ((state_reg == S_WAIT) && mrsp.done)
        begin
            case (op_reg)
                OP_FNV, OP_FIN_P_A, OP_FIN_P_B: prim_next = mrsp.product;
                default:                        sec_next  = mrsp.product;
            endcase
        end
        if (out_load)
        begin
            prim_next      = FNV_BASIS;
            sec_next       = GOLDEN_SEED;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_FNV;
            prim_reg      <= FNV_BASIS;
            sec_reg       <= GOLDEN_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            prim_reg      <= prim_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (in_accept)
        begin
            byte_reg <= data_byte;
            last_reg <= last;
        end
        if (out_load)
        begin
            digest_high_reg <= prim_reg ^ (prim_reg >> 31);
            digest_low_reg  <= sec_reg ^ (sec_reg >> 31);
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_high = digest_high_reg;
    assign digest_low  = digest_low_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg == S_WAIT)
        else $error("multiply result arrived outside wait state");

    a_start_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_START && op_reg == OP_FNV)
        else $error("accepted byte did not start the primary multiply");

    a_load_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_OUT) |-> $past(op_reg) == OP_FIN_S_B && $past(last_reg))
        else $error("digest stage entered without full finalizer");

    a_lanes_reseeded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> prim_reg == FNV_BASIS && sec_reg == GOLDEN_SEED)
        else $error("lanes not reseeded after digest");

endmodule

FILE: verif/tb.sv
class digest_board;
    logic [63:0] fnv_lane;
    logic [63:0] mix_lane;
    logic [63:0] want_high[$];
    logic [63:0] want_low[$];
    int          errors;

    function new();
        fnv_lane = dbh_pkg::FNV_BASIS;
        mix_lane = dbh_pkg::GOLDEN_SEED;
        errors   = 0;
    endfunction

    function logic [63:0] splitmix_final(input logic [63:0] v);
        v = v ^ (v >> 30);
        v = v * dbh_pkg::MIX_MULT_A;
        v = v ^ (v >> 27);
        v = v * dbh_pkg::MIX_MULT_B;
        v = v ^ (v >> 31);
        return v;
    endfunction

    // Absorbs one accepted request; a byte marked last queues the digest it closes.
    function void note_byte(input logic [7:0] b, input logic is_last);
        logic [63:0] s;
        s        = mix_lane;
        fnv_lane = (fnv_lane ^ {56'd0, b}) * dbh_pkg::FNV64_MUL;
        // Every term on the right side uses the old secondary lane.
        s        = s ^ ({56'd0, b} + dbh_pkg::GOLDEN_SEED + (s << 6) + (s >> 2));
        s        = {s[50:0], s[63:51]};
        mix_lane = s * dbh_pkg::MIX_MULT_A;
        if (is_last)
        begin
            want_high.push_back(splitmix_final(fnv_lane));
            want_low.push_back(splitmix_final(mix_lane));
            fnv_lane = dbh_pkg::FNV_BASIS;
            mix_lane = dbh_pkg::GOLDEN_SEED;
        end
    endfunction

    function void check_digest(input logic [63:0] high, input logic [63:0] low);
        logic [63:0] exp_high;
        logic [63:0] exp_low;
        if (want_high.size() == 0)
        begin
            $display("%0t unexpected digest: expected none, got %h %h", $time, high, low);
            errors++;
            return;
        end
        exp_high = want_high.pop_front();
        exp_low  = want_low.pop_front();
        if (high !== exp_high)
        begin
            $display("%0t digest_high mismatch: expected %h, got %h", $time, exp_high, high);
            errors++;
        end
        if (low !== exp_low)
        begin
            $display("%0t digest_low mismatch: expected %h, got %h", $time, exp_low, low);
            errors++;
        end
    endfunction

    function int pending();
        return want_high.size();
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_high;
    logic [63:0] digest_low;

    digest_board digests;
    int          send_idle;
    int          recv_idle;
    bit          hold_request;
    int          hold_left;
    int          cycle_count;

    dual_64bit_byte_hash DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_high (digest_high),
        .digest_low  (digest_low)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: checks each accepted digest, then picks out_ready for the next edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            digests.check_digest(digest_high, digest_low);
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (rst_n !== 1'b1)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic offer_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        digests.note_byte(b, is_last);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Whole messages with random content: mostly short, now and then long.
    task automatic random_messages(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
                offer_byte(pick_byte(), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        logic [63:0] word;
        digests      = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        last         = 1'b0;
        out_ready    = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        send_idle    = 16;
        recv_idle    = 78;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte messages at both extremes, then short runs of fixed patterns.
        offer_byte(8'h00, 1'b1);
        offer_byte(8'hff, 1'b1);
        for (int i = 0; i < 4; i++)
            offer_byte(8'hff, i == 3);
        for (int i = 0; i < 4; i++)
            offer_byte(8'h00, i == 3);
        for (int i = 0; i < 4; i++)
            offer_byte(i[0] ? 8'haa : 8'h55, i == 3);
        // An integer framed as eight little-endian bytes.
        word = 64'h0123456789abcdef;
        for (int i = 0; i < 8; i++)
            offer_byte(word[8*i +: 8], i == 7);
        offer_byte(8'h80, 1'b1);
        offer_byte(8'h01, 1'b1);

        random_messages(110);

        send_idle = 78;
        recv_idle = 16;
        random_messages(135);

        send_idle = 0;
        recv_idle = 0;
        // The output stays blocked while digests pile up and the input backs up.
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++)
            offer_byte(pick_byte(), 1'b1);
        random_messages(115);

        in_valid <= 1'b0;
        while (digests.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (digests.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
